// File: rtl/core/rrsp_pkg.sv
// Package for the replay record stream parser: phase codes, result kinds,
// result record type and sizing constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rrsp_pkg;

  localparam int VarintMaxBytesDef = 10;
  localparam logic [23:0] MagicWord = 24'h474452;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_VERSION, PH_TAG_LEN, PH_TAG_SKIP, PH_AUTHOR_LEN, PH_AUTHOR_SKIP,
    PH_DESC_LEN, PH_DESC_SKIP, PH_DURATION, PH_GAMEVER, PH_RATE, PH_SEED,
    PH_COINS, PH_LDM, PH_PLAT, PH_BOT_LEN, PH_BOT_SKIP, PH_BOTVER, PH_LEVEL,
    PH_LNAME_LEN, PH_LNAME_SKIP, PH_EXT_LEN, PH_EXT_SKIP, PH_DEATH_COUNT,
    PH_DEATH, PH_TOTAL, PH_P1, PH_PACKED, PH_IEXT_LEN, PH_IEXT_SKIP
  } phase_t;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_DEATH  = 3'd1;
  localparam logic [2:0] KIND_INPUT  = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [3:0] HF_VERSION  = 4'd0;
  localparam logic [3:0] HF_DURATION = 4'd1;
  localparam logic [3:0] HF_GAMEVER  = 4'd2;
  localparam logic [3:0] HF_RATE     = 4'd3;
  localparam logic [3:0] HF_SEED     = 4'd4;
  localparam logic [3:0] HF_COINS    = 4'd5;
  localparam logic [3:0] HF_LDM      = 4'd6;
  localparam logic [3:0] HF_PLAT     = 4'd7;
  localparam logic [3:0] HF_BOTVER   = 4'd8;
  localparam logic [3:0] HF_LEVEL    = 4'd9;

  localparam logic ERR_MAGIC = 1'b0;
  localparam logic ERR_EOF   = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  header_field;
    logic [63:0] value;
    logic [1:0]  button;
    logic        pressed;
    logic        second_player;
    logic        error_code;
    logic        final_res;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/rrsp_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on rrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last_byte;
  modport source (output valid, output byte_req, output last_byte, input ready);
  modport sink (input valid, input byte_req, input last_byte, output ready);
endinterface

interface rrsp_res_if;
  logic                 valid;
  logic                 ready;
  rrsp_pkg::result_t    res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rrsp_front.sv
// Front end: accepts bytes, runs the phase machine and varint accumulation,
// and pushes classified results. Depends on rrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrsp_front #(
  parameter int VARINT_MAX_BYTES = rrsp_pkg::VarintMaxBytesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte_req,
  input  wire logic              in_last_byte,
  output logic                   push,
  output rrsp_pkg::result_t      push_res,
  input  wire logic              q_full
);
  import rrsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] vv_r, vv_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [63:0] skip_r, skip_nxt;
  logic [63:0] dleft_r, dleft_nxt;
  logic [63:0] dtot_r, dtot_nxt;
  logic [63:0] fbase_r, fbase_nxt;
  logic [63:0] p1_r, p1_nxt;
  logic        plat_r, plat_nxt;
  logic        hext_r, hext_nxt;
  logic        failed_r, failed_nxt;

  logic        acc;
  logic [63:0] vsum, fsum, delta, frame;
  logic        vdone, fdone;
  logic [6:0]  sh;
  logic [3:0]  fneed;
  logic        emit, is_err, clean;
  result_t     r;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;

  always_comb begin
    sh = 7'(7 * vcnt_r);
    vsum = vv_r;
    if (sh < 7'd64) vsum = vv_r + ({56'd0, 1'b0, in_byte_req[6:0]} << sh);
    vdone = !in_byte_req[7] || (32'(vcnt_r) + 1 >= VARINT_MAX_BYTES);
    fsum = {vv_r[55:0], in_byte_req};
    case (phase_r)
      PH_MAGIC:    fneed = 4'd3;
      PH_DURATION: fneed = 4'd4;
      default:     fneed = 4'd8;
    endcase
    fdone = (vcnt_r + 4'd1) >= fneed;
    delta = plat_r ? {3'd0, vsum[63:3]} : {1'b0, vsum[63:1]};
    frame = delta + fbase_r;
  end

  always_comb begin
    phase_nxt = phase_r; vv_nxt = vv_r; vcnt_nxt = vcnt_r; skip_nxt = skip_r;
    dleft_nxt = dleft_r; dtot_nxt = dtot_r; fbase_nxt = fbase_r; p1_nxt = p1_r;
    plat_nxt = plat_r; hext_nxt = hext_r; failed_nxt = failed_r;
    r = '0; emit = 1'b0; is_err = 1'b0; clean = 1'b0;
    if (acc && failed_r) begin
      if (in_last_byte) begin
        phase_nxt = PH_MAGIC; vv_nxt = '0; vcnt_nxt = '0; skip_nxt = '0; dleft_nxt = '0;
        dtot_nxt = '0; fbase_nxt = '0; p1_nxt = '0; plat_nxt = 1'b0; hext_nxt = 1'b0;
        failed_nxt = 1'b0;
      end
    end else if (acc) begin
      case (phase_r)
        PH_MAGIC, PH_DURATION, PH_RATE: begin
          vv_nxt = fsum; vcnt_nxt = vcnt_r + 4'd1;
          if (fdone) begin
            vv_nxt = '0; vcnt_nxt = '0;
            if (phase_r == PH_MAGIC) begin
              if (fsum[23:0] != MagicWord) begin
                r.kind = KIND_ERROR; r.error_code = ERR_MAGIC; r.final_res = 1'b1;
                emit = 1'b1; is_err = 1'b1; failed_nxt = 1'b1;
              end else begin
                phase_nxt = PH_VERSION;
              end
            end else begin
              r.kind = KIND_HEADER; r.value = fsum; emit = 1'b1;
              r.header_field = (phase_r == PH_DURATION) ? HF_DURATION : HF_RATE;
              phase_nxt = (phase_r == PH_DURATION) ? PH_GAMEVER : PH_SEED;
            end
          end
        end
        PH_TAG_SKIP, PH_AUTHOR_SKIP, PH_DESC_SKIP, PH_BOT_SKIP, PH_LNAME_SKIP,
        PH_EXT_SKIP, PH_IEXT_SKIP: begin
          skip_nxt = skip_r - 64'd1;
          if (skip_nxt == '0)
            phase_nxt = (phase_r == PH_IEXT_SKIP) ? PH_PACKED : phase_t'(phase_r + 5'd1);
        end
        PH_VERSION, PH_TAG_LEN, PH_AUTHOR_LEN, PH_DESC_LEN, PH_GAMEVER, PH_SEED,
        PH_COINS, PH_LDM, PH_PLAT, PH_BOT_LEN, PH_BOTVER, PH_LEVEL, PH_LNAME_LEN,
        PH_EXT_LEN, PH_DEATH_COUNT, PH_DEATH, PH_TOTAL, PH_P1, PH_PACKED,
        PH_IEXT_LEN: begin
          vv_nxt = vsum; vcnt_nxt = vcnt_r + 4'd1;
          if (vdone) begin
            vv_nxt = '0; vcnt_nxt = '0;
            case (phase_r)
              PH_VERSION: begin
                r.header_field = HF_VERSION; r.value = vsum; emit = 1'b1;
                phase_nxt = PH_TAG_LEN;
              end
              PH_GAMEVER: begin
                r.header_field = HF_GAMEVER; r.value = vsum; emit = 1'b1; phase_nxt = PH_RATE;
              end
              PH_SEED: begin
                r.header_field = HF_SEED; r.value = vsum; emit = 1'b1; phase_nxt = PH_COINS;
              end
              PH_COINS: begin
                r.header_field = HF_COINS; r.value = vsum; emit = 1'b1; phase_nxt = PH_LDM;
              end
              PH_LDM: begin
                r.header_field = HF_LDM; r.value = {63'd0, vsum != '0}; emit = 1'b1;
                phase_nxt = PH_PLAT;
              end
              PH_PLAT: begin
                plat_nxt = vsum != '0;
                r.header_field = HF_PLAT; r.value = {63'd0, plat_nxt}; emit = 1'b1;
                phase_nxt = PH_BOT_LEN;
              end
              PH_BOTVER: begin
                r.header_field = HF_BOTVER; r.value = vsum; emit = 1'b1; phase_nxt = PH_LEVEL;
              end
              PH_LEVEL: begin
                r.header_field = HF_LEVEL; r.value = vsum; emit = 1'b1;
                phase_nxt = PH_LNAME_LEN;
              end
              PH_DEATH_COUNT: begin
                dleft_nxt = vsum;
                phase_nxt = (vsum != '0) ? PH_DEATH : PH_TOTAL;
              end
              PH_DEATH: begin
                dtot_nxt = dtot_r + vsum;
                r.kind = KIND_DEATH; r.value = {32'd0, dtot_nxt[31:0]}; emit = 1'b1;
                dleft_nxt = dleft_r - 64'd1;
                if (dleft_nxt == '0) phase_nxt = PH_TOTAL;
              end
              PH_TOTAL: phase_nxt = PH_P1;
              PH_P1: begin
                p1_nxt = vsum; phase_nxt = PH_PACKED;
              end
              PH_PACKED: begin
                r.kind = KIND_INPUT; r.value = {32'd0, frame[31:0]};
                r.button = plat_r ? vsum[2:1] : 2'd1;
                r.pressed = vsum[0]; r.second_player = (p1_r == '0); emit = 1'b1;
                fbase_nxt = frame;
                if (p1_r != '0) begin
                  p1_nxt = p1_r - 64'd1;
                  if (p1_nxt == '0) fbase_nxt = '0;
                end
                phase_nxt = hext_r ? PH_IEXT_LEN : PH_PACKED;
              end
              PH_IEXT_LEN: begin
                skip_nxt = vsum;
                phase_nxt = (vsum == '0) ? PH_PACKED : PH_IEXT_SKIP;
              end
              default: begin
                if (phase_r == PH_TAG_LEN) hext_nxt = vsum != '0;
                if (vsum == '0) begin
                  phase_nxt = phase_t'(phase_r + 5'd2);
                end else begin
                  skip_nxt = vsum; phase_nxt = phase_t'(phase_r + 5'd1);
                end
              end
            endcase
          end
        end
        default: ;
      endcase
      if (in_last_byte) begin
        if (!is_err) begin
          clean = (phase_nxt == PH_PACKED) && (vcnt_nxt == '0);
          if (clean) begin
            if (!emit) begin
              r = '0; r.kind = KIND_END; emit = 1'b1;
            end
            r.final_res = 1'b1;
          end else begin
            r = '0; r.kind = KIND_ERROR; r.error_code = ERR_EOF; r.final_res = 1'b1;
            emit = 1'b1;
          end
        end
        phase_nxt = PH_MAGIC; vv_nxt = '0; vcnt_nxt = '0; skip_nxt = '0; dleft_nxt = '0;
        dtot_nxt = '0; fbase_nxt = '0; p1_nxt = '0; plat_nxt = 1'b0; hext_nxt = 1'b0;
        failed_nxt = 1'b0;
      end
    end
  end

  assign push = emit;
  assign push_res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; vv_r <= '0; vcnt_r <= '0; skip_r <= '0; dleft_r <= '0;
      dtot_r <= '0; fbase_r <= '0; p1_r <= '0; plat_r <= 1'b0; hext_r <= 1'b0;
      failed_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; vv_r <= vv_nxt; vcnt_r <= vcnt_nxt; skip_r <= skip_nxt;
      dleft_r <= dleft_nxt; dtot_r <= dtot_nxt; fbase_r <= fbase_nxt; p1_r <= p1_nxt;
      plat_r <= plat_nxt; hext_r <= hext_nxt; failed_r <= failed_nxt;
    end
  end

  ap_push_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc) else $error("result pushed without an accepted beat");
  ap_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !push) else $error("result after bad magic");
  ap_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_byte && !failed_r) |-> (push && push_res.final_res))
    else $error("last beat gave no final result");
endmodule
`default_nettype wire

// File: rtl/core/rrsp_queue.sv
// Two-entry result queue between the parser front and the output side.
// Depends on rrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrsp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rrsp_pkg::result_t push_res,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rrsp_pkg::result_t  out_res
);
  import rrsp_pkg::*;

  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_res = mem_r[rp_r];
  assign pop = out_valid && out_ready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  ap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wp_r == rp_r)) else $error("queue pointers disagree");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("queued result lost");
endmodule
`default_nettype wire

// File: rtl/core/replay_record_stream_parser.sv
// Replay record stream parser. One input beat carries a file byte and a
// last flag; one output beat carries a classified result record.
// The byte channel feeds a front end holding the parse phase and varint
// accumulator; each accepted beat is fully decoded in that same cycle.
// Results go into a two-entry queue that drives the result channel.
// Throughput is one byte per cycle while the queue has a free slot.
// A result enters the queue when its byte is accepted, behind any waiting results.
// Bytes that only advance the parse give no beat.
// If the receiver stalls, the queue fills and input ready drops once two
// results wait; bytes are taken again as soon as a slot frees.
// The byte flagged last always produces a final result (end, last input
// frame, or error), except after a bad magic, which already sent its final
// error and swallows the rest of the file.
// Synchronous reset returns the parser to the magic phase and empties the
// queue. Depends on rrsp_pkg, rrsp_if, rrsp_front and rrsp_queue.
`timescale 1ns / 1ps
`default_nettype none
module replay_record_stream_parser #(
  parameter int VARINT_MAX_BYTES = rrsp_pkg::VarintMaxBytesDef
) (
  input wire logic clk,
  input wire logic rst_n,
  rrsp_byte_if.sink  in_ch,
  rrsp_res_if.source out_ch
);
  import rrsp_pkg::*;

  logic    push, full;
  result_t push_res;

  rrsp_front #(.VARINT_MAX_BYTES(VARINT_MAX_BYTES)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte_req(in_ch.byte_req), .in_last_byte(in_ch.last_byte),
    .push, .push_res, .q_full(full)
  );

  rrsp_queue u_queue (
    .clk, .rst_n, .push, .push_res, .full,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.res)
  );
endmodule
`default_nettype wire
